// ===== hw/rtl/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// Plummer acceleration package
// Shared constants and register indexes for the Plummer sphere accelerator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 8;

   localparam logic [CSR_DATA_BITS-1:0] GM_TOTAL_RESET     = 32'd65536;
   localparam logic [CSR_DATA_BITS-1:0] RADIUS_SCALE_RESET = 32'd148106;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GM_TOTAL     = 8'd0,
      CSR_RADIUS_SCALE = 8'd1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ppa_if.sv =====
// ----------------------------------------------------------------------------
// Plummer acceleration channels
// Valid/ready channels for particles, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppa_req_if
   import ppa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] pos_x;
   logic signed [WORD_BITS-1:0] pos_y;
   logic signed [WORD_BITS-1:0] pos_z;
   logic signed [WORD_BITS-1:0] acc_in_x;
   logic signed [WORD_BITS-1:0] acc_in_y;
   logic signed [WORD_BITS-1:0] acc_in_z;
   logic                        last_in;

   modport source (output valid, pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z,
                   last_in, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, acc_in_x, acc_in_y, acc_in_z,
                   last_in, output ready);
endinterface

interface ppa_rsp_if
   import ppa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] acc_out_x;
   logic signed [WORD_BITS-1:0] acc_out_y;
   logic signed [WORD_BITS-1:0] acc_out_z;
   logic                        saturated;
   logic                        last_out;

   modport source (output valid, acc_out_x, acc_out_y, acc_out_z, saturated, last_out,
                   input ready);
   modport sink   (input valid, acc_out_x, acc_out_y, acc_out_z, saturated, last_out,
                   output ready);
endinterface

interface ppa_csr_if
   import ppa_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plummer_potential_accel.sv =====
// ----------------------------------------------------------------------------
// Plummer sphere acceleration
// Adds the pull of a Plummer sphere at the origin to each particle's
// acceleration, in saturating fixed point.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_bus   in         position, acceleration and last flag of one particle
//  rsp_bus   out        updated acceleration, saturated flag, last flag
//  csr_bus   in         register index and data, always ready
//
//  One item enters per cycle while the skid register is empty. With the default widths
//  the pipeline holds 24 square-root steps and 48 restoring-division steps, one per stage.
//  Reset clears all valid bits and restores the register defaults.
//  A stalled result sits in the output register and a one-item skid register
//  takes the next one, so the pipeline freezes only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module plummer_potential_accel
   import ppa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   ppa_req_if.sink     req_bus,
   ppa_rsp_if.source   rsp_bus,
   ppa_csr_if.sink     csr_bus
);

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;
   localparam int NS  = (W + F + 1) / 2;
   localparam int NN  = W + F;
   localparam int TW  = W + F + 3;

   localparam int ST_ABS   = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_R2    = 3;
   localparam int ST_T     = 4;
   localparam int ST_SQRT0 = 5;
   localparam int ST_TQ    = ST_SQRT0 + NS;
   localparam int ST_D     = ST_TQ + 1;
   localparam int ST_DIV0  = ST_D + 1;
   localparam int ST_C     = ST_DIV0 + NN;
   localparam int ST_OUT   = ST_C + 1;
   localparam int NST      = ST_OUT + 1;

   localparam logic [W-1:0]  SIGN_BIT = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  WORD_MAX = {W{1'b1}};
   localparam logic [TW-1:0] THREE_Q  = TW'(3) << F;

   typedef struct packed {
      logic [2:0][W-1:0]  mag;
      logic [2:0][W-1:0]  acc;
      logic [2:0]         neg;
      logic               last;
      logic               sat;
      logic [W-1:0]       k2;
      logic [W-1:0]       k3;
      logic [W-1:0]       g;
      logic [2:0][PW-1:0] sq;
      logic [PW+1:0]      sum;
      logic [PW-1:0]      prod;
      logic [W-1:0]       t;
      logic [NS+1:0]      srem;
      logic [NS-1:0]      root;
      logic [W-1:0]       d;
      logic [W:0]         drem;
      logic [NN-1:0]      quot;
   } stage_type;

   typedef struct packed {
      logic [2:0][W-1:0] acc;
      logic              sat;
      logic              last;
   } result_type;

   function automatic logic [W:0] mul_clip(input logic [PW-1:0] prod);
      logic [PW-1:0] sh;
      sh = prod >> F;
      if ((sh >> W) != '0) begin
         mul_clip = {1'b1, WORD_MAX};
      end else begin
         mul_clip = {1'b0, sh[W-1:0]};
      end
   endfunction

   logic [CSR_DATA_BITS-1:0] gm_total_ff;
   logic [CSR_DATA_BITS-1:0] radius_scale_ff;
   logic [W-1:0]             k_word;
   logic [W-1:0]             gm_word;

   stage_type  pipe_ff [NST];
   stage_type  pipe_in [NST];
   logic [NST-1:0] valid_ff;
   logic       adv;

   result_type out_ff, sk_ff;
   result_type last_res;
   logic       out_valid_ff, out_valid_in;
   logic       sk_valid_ff, sk_valid_in;

   assign k_word  = W'(radius_scale_ff);
   assign gm_word = W'(gm_total_ff);

   // Register writes.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gm_total_ff     <= GM_TOTAL_RESET;
         radius_scale_ff <= RADIUS_SCALE_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == CSR_GM_TOTAL) begin
            gm_total_ff <= csr_bus.data;
         end else if (csr_bus.index == CSR_RADIUS_SCALE) begin
            radius_scale_ff <= csr_bus.data;
         end
      end
   end

   // Pipeline stages.
   for (genvar s = 0; s < NST; s++) begin : g_stage
      stage_type nx;
      assign pipe_in[s] = nx;

      if (s == ST_ABS) begin : g_abs
         logic [2:0][W-1:0] pos;
         logic [W:0]        k2c;
         assign pos = {W'(req_bus.pos_z), W'(req_bus.pos_y), W'(req_bus.pos_x)};
         assign k2c = mul_clip(PW'(k_word) * PW'(k_word));
         always_comb begin
            nx = '0;
            for (int i = 0; i < 3; i++) begin
               nx.neg[i] = pos[i][W-1];
               nx.mag[i] = pos[i][W-1] ? W'(-pos[i]) : pos[i];
            end
            nx.acc  = {W'(req_bus.acc_in_z), W'(req_bus.acc_in_y), W'(req_bus.acc_in_x)};
            nx.last = req_bus.last_in;
            nx.k2   = k2c[W-1:0];
            nx.sat  = k2c[W];
         end
      end else if (s == ST_SQ) begin : g_sq
         logic [W:0] k3c;
         assign k3c = mul_clip(PW'(pipe_ff[s-1].k2) * PW'(k_word));
         always_comb begin
            nx = pipe_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               nx.sq[i] = PW'(pipe_ff[s-1].mag[i]) * PW'(pipe_ff[s-1].mag[i]);
            end
            nx.k3  = k3c[W-1:0];
            nx.sat = pipe_ff[s-1].sat | k3c[W];
         end
      end else if (s == ST_SUM) begin : g_sum
         logic [W:0] gc;
         assign gc = mul_clip(PW'(gm_word) * PW'(pipe_ff[s-1].k3));
         always_comb begin
            nx     = pipe_ff[s-1];
            nx.sum = (PW+2)'(pipe_ff[s-1].sq[0]) + (PW+2)'(pipe_ff[s-1].sq[1])
                   + (PW+2)'(pipe_ff[s-1].sq[2]);
            nx.g   = gc[W-1:0];
            nx.sat = pipe_ff[s-1].sat | gc[W];
         end
      end else if (s == ST_R2) begin : g_r2
         logic [PW+1:0] sh;
         logic          ovf;
         logic [W-1:0]  r2;
         assign sh  = pipe_ff[s-1].sum >> F;
         assign ovf = (sh >> W) != '0;
         assign r2  = ovf ? WORD_MAX : sh[W-1:0];
         always_comb begin
            nx      = pipe_ff[s-1];
            nx.prod = PW'(r2) * PW'(pipe_ff[s-1].k2);
            nx.sat  = pipe_ff[s-1].sat | ovf;
         end
      end else if (s == ST_T) begin : g_t
         logic [W:0]    s2c;
         logic [TW-1:0] tsum;
         logic          tovf;
         assign s2c  = mul_clip(pipe_ff[s-1].prod);
         assign tsum = TW'(s2c[W-1:0]) + THREE_Q;
         assign tovf = (tsum >> W) != '0;
         always_comb begin
            nx      = pipe_ff[s-1];
            nx.t    = tovf ? WORD_MAX : tsum[W-1:0];
            nx.sat  = pipe_ff[s-1].sat | s2c[W] | tovf;
            nx.srem = '0;
            nx.root = '0;
         end
      end else if (s >= ST_SQRT0 && s < ST_TQ) begin : g_sqrt
         localparam int J = s - ST_SQRT0;
         logic [2*NS-1:0] npad;
         logic [NS+1:0]   rsh;
         logic [NS+1:0]   trial;
         assign npad  = (2*NS)'(pipe_ff[s-1].t) << F;
         assign rsh   = {pipe_ff[s-1].srem[NS-1:0], npad[2*(NS-1-J) +: 2]};
         assign trial = {pipe_ff[s-1].root, 2'b01};
         always_comb begin
            nx = pipe_ff[s-1];
            if (rsh >= trial) begin
               nx.srem = rsh - trial;
               nx.root = {pipe_ff[s-1].root[NS-2:0], 1'b1};
            end else begin
               nx.srem = rsh;
               nx.root = {pipe_ff[s-1].root[NS-2:0], 1'b0};
            end
         end
      end else if (s == ST_TQ) begin : g_tq
         logic [NS+W-1:0] qext;
         logic            qovf;
         logic [W-1:0]    q;
         assign qext = (NS+W)'(pipe_ff[s-1].root);
         assign qovf = (qext >> W) != '0;
         assign q    = qovf ? WORD_MAX : qext[W-1:0];
         always_comb begin
            nx      = pipe_ff[s-1];
            nx.prod = PW'(pipe_ff[s-1].t) * PW'(q);
            nx.sat  = pipe_ff[s-1].sat | qovf;
         end
      end else if (s == ST_D) begin : g_d
         logic [W:0] dc;
         assign dc = mul_clip(pipe_ff[s-1].prod);
         always_comb begin
            nx      = pipe_ff[s-1];
            nx.d    = (dc[W-1:0] == '0) ? W'(1) : dc[W-1:0];
            nx.sat  = pipe_ff[s-1].sat | dc[W];
            nx.drem = '0;
            nx.quot = '0;
         end
      end else if (s >= ST_DIV0 && s < ST_C) begin : g_div
         localparam int J = s - ST_DIV0;
         logic [NN-1:0] num;
         logic [W:0]    rsh;
         assign num = NN'(pipe_ff[s-1].g) << F;
         assign rsh = {pipe_ff[s-1].drem[W-1:0], num[NN-1-J]};
         always_comb begin
            nx = pipe_ff[s-1];
            if (rsh >= {1'b0, pipe_ff[s-1].d}) begin
               nx.drem = rsh - {1'b0, pipe_ff[s-1].d};
               nx.quot = {pipe_ff[s-1].quot[NN-2:0], 1'b1};
            end else begin
               nx.drem = rsh;
               nx.quot = {pipe_ff[s-1].quot[NN-2:0], 1'b0};
            end
         end
      end else if (s == ST_C) begin : g_c
         logic         covf;
         logic [W-1:0] c;
         assign covf = (pipe_ff[s-1].quot >> W) != '0;
         assign c    = covf ? WORD_MAX : pipe_ff[s-1].quot[W-1:0];
         always_comb begin
            nx = pipe_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               nx.sq[i] = PW'(c) * PW'(pipe_ff[s-1].mag[i]);
            end
            nx.sat = pipe_ff[s-1].sat | covf;
         end
      end else begin : g_out
         logic [2:0][PW-1:0] m;
         logic [2:0][PW-1:0] biased;
         logic [2:0][PW-1:0] up;
         for (genvar i = 0; i < 3; i++) begin : g_axis
            assign m[i]      = pipe_ff[s-1].sq[i] >> F;
            assign biased[i] = PW'(pipe_ff[s-1].acc[i] ^ SIGN_BIT);
            assign up[i]     = biased[i] + m[i];
         end
         always_comb begin
            nx = pipe_ff[s-1];
            for (int i = 0; i < 3; i++) begin
               if (pipe_ff[s-1].mag[i] == '0) begin
                  nx.acc[i] = pipe_ff[s-1].acc[i];
               end else if (!pipe_ff[s-1].neg[i]) begin
                  if (biased[i] < m[i]) begin
                     nx.sat    = 1'b1;
                     nx.acc[i] = SIGN_BIT;
                  end else begin
                     nx.acc[i] = W'(biased[i] - m[i]) ^ SIGN_BIT;
                  end
               end else begin
                  if (up[i] > PW'(WORD_MAX)) begin
                     nx.sat    = 1'b1;
                     nx.acc[i] = ~SIGN_BIT;
                  end else begin
                     nx.acc[i] = up[i][W-1:0] ^ SIGN_BIT;
                  end
               end
            end
         end
      end
   end

   assign adv           = !sk_valid_ff;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NST; s++) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   // Output register and skid register.
   assign last_res.acc  = pipe_ff[NST-1].acc;
   assign last_res.sat  = pipe_ff[NST-1].sat;
   assign last_res.last = pipe_ff[NST-1].last;

   always_comb begin
      out_valid_in = out_valid_ff;
      sk_valid_in  = sk_valid_ff;
      if (sk_valid_ff) begin
         if (rsp_bus.ready) begin
            out_valid_in = 1'b1;
            sk_valid_in  = 1'b0;
         end
      end else if (out_valid_ff && !rsp_bus.ready) begin
         sk_valid_in = valid_ff[NST-1];
      end else begin
         out_valid_in = valid_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sk_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sk_valid_ff  <= sk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sk_valid_ff) begin
         if (rsp_bus.ready) begin
            out_ff <= sk_ff;
         end
      end else if (out_valid_ff && !rsp_bus.ready) begin
         sk_ff <= last_res;
      end else begin
         out_ff <= last_res;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.acc_out_x = out_ff.acc[0];
   assign rsp_bus.acc_out_y = out_ff.acc[1];
   assign rsp_bus.acc_out_z = out_ff.acc[2];
   assign rsp_bus.saturated = out_ff.sat;
   assign rsp_bus.last_out  = out_ff.last;

endmodule

`default_nettype wire

// ===== verif/plummer_potential_accel_tb.sv =====
// ----------------------------------------------------------------------------
// Plummer acceleration testbench
// Streams particles through the accelerator under random idling on both
// channels, predicts each updated acceleration in saturating fixed point and
// compares every result field by field, over several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module plummer_potential_accel_tb;
   import ppa_pkg::*;

   localparam int FB = 16;
   localparam int WB = 32;
   localparam logic [63:0] WMASK = 64'hFFFF_FFFF;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam int LATENCY = 81;

   typedef struct packed {
      logic [31:0] pos_x, pos_y, pos_z, acc_x, acc_y, acc_z;
      logic        last;
   } particle_type;

   typedef struct packed {
      logic [31:0] acc_x, acc_y, acc_z;
      logic        sat;
      logic        last;
   } accel_type;

   typedef struct {
      particle_type p;
      logic         known;
      accel_type    r;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppa_req_if #(.WORD_BITS(WB)) req_bus ();
   ppa_rsp_if #(.WORD_BITS(WB)) rsp_bus ();
   ppa_csr_if                   csr_bus ();

   plummer_potential_accel #(.FRAC_BITS(FB), .WORD_BITS(WB)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [31:0] gm_setting, scale_setting;
   accel_type   pending_accel[$];
   int          fail_count = 0;
   int          result_count = 0;
   int          saturated_count = 0;
   int          idle_pct = 13;

   function automatic logic [63:0] clip_word(logic [127:0] v, ref logic flag);
      if (v > {64'd0, WMASK}) begin
         flag = 1'b1;
         return WMASK;
      end
      return v[63:0];
   endfunction

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
      end
      return res;
   endfunction

   function automatic logic [31:0] pull_axis(logic [31:0] pos, logic [31:0] acc,
                                             logic [63:0] c, ref logic flag);
      logic [63:0]  mag;
      logic [127:0] m, biased, res;
      mag = pos[31] ? {32'd0, -pos} : {32'd0, pos};
      if (mag == 0) return acc;
      m = ({64'd0, c} * {64'd0, mag}) >> FB;
      biased = {96'd0, acc ^ SIGN_BIT};
      if (!pos[31]) begin
         if (biased < m) begin
            flag = 1'b1;
            res = '0;
         end else begin
            res = biased - m;
         end
      end else begin
         res = biased + m;
         if (res > {64'd0, WMASK}) begin
            flag = 1'b1;
            res = {64'd0, WMASK};
         end
      end
      return res[31:0] ^ SIGN_BIT;
   endfunction

   function automatic accel_type plummer_pull(particle_type p);
      logic        flag;
      logic [63:0] k, k2, k3, g, r2, s2, t, q, d, c, mx, my, mz;
      logic [127:0] sum;
      accel_type   r;
      flag = 1'b0;
      k = {32'd0, scale_setting};
      mx = p.pos_x[31] ? {32'd0, -p.pos_x} : {32'd0, p.pos_x};
      my = p.pos_y[31] ? {32'd0, -p.pos_y} : {32'd0, p.pos_y};
      mz = p.pos_z[31] ? {32'd0, -p.pos_z} : {32'd0, p.pos_z};
      k2 = clip_word(({64'd0, k} * k) >> FB, flag);
      k3 = clip_word(({64'd0, k2} * k) >> FB, flag);
      g = clip_word(({96'd0, gm_setting} * k3) >> FB, flag);
      sum = {64'd0, mx} * mx + {64'd0, my} * my + {64'd0, mz} * mz;
      r2 = clip_word(sum >> FB, flag);
      s2 = clip_word(({64'd0, r2} * k2) >> FB, flag);
      t = clip_word({64'd0, s2} + (128'd3 << FB), flag);
      q = clip_word({64'd0, isqrt({64'd0, t} << FB)}, flag);
      d = clip_word(({64'd0, t} * q) >> FB, flag);
      if (d == 0) d = 1;
      c = clip_word(({64'd0, g} << FB) / d, flag);
      r.acc_x = pull_axis(p.pos_x, p.acc_x, c, flag);
      r.acc_y = pull_axis(p.pos_y, p.acc_y, c, flag);
      r.acc_z = pull_axis(p.pos_z, p.acc_z, c, flag);
      r.sat = flag;
      r.last = p.last;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return {{16{1'b0}}, 16'($urandom())};
         2: return -{{16{1'b0}}, 16'($urandom())};
         3: return 32'd0;
         default: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic particle_type rand_particle();
      particle_type p;
      p.pos_x = rand_coord();
      p.pos_y = rand_coord();
      p.pos_z = rand_coord();
      p.acc_x = ($urandom_range(0, 3) == 0) ? $urandom() : rand_coord();
      p.acc_y = ($urandom_range(0, 3) == 0) ? $urandom() : rand_coord();
      p.acc_z = ($urandom_range(0, 3) == 0) ? $urandom() : rand_coord();
      p.last = $urandom_range(0, 7) == 0;
      return p;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_GM_TOTAL) gm_setting = value;
      else scale_setting = value;
      @(posedge clock);
   endtask

   task automatic send_particle(particle_type p, logic known, accel_type r);
      accel_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      predicted = plummer_pull(p);
      if (known && predicted !== r) begin
         $display("%0t table row expected %h actual predictor %h", $time, r, predicted);
         fail_count++;
      end
      req_bus.valid    <= 1'b1;
      req_bus.pos_x    <= p.pos_x;
      req_bus.pos_y    <= p.pos_y;
      req_bus.pos_z    <= p.pos_z;
      req_bus.acc_in_x <= p.acc_x;
      req_bus.acc_in_y <= p.acc_y;
      req_bus.acc_in_z <= p.acc_z;
      req_bus.last_in  <= p.last;
      do @(posedge clock); while (!req_bus.ready);
      pending_accel.push_back(known ? r : predicted);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_accel.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_accel.size() == 0) begin
               $display("%0t unexpected item: %h", $time,
                        {rsp_bus.acc_out_x, rsp_bus.acc_out_y, rsp_bus.acc_out_z});
               fail_count++;
            end else begin
               accel_type want;
               accel_type got;
               want = pending_accel.pop_front();
               got = {rsp_bus.acc_out_x, rsp_bus.acc_out_y, rsp_bus.acc_out_z,
                      rsp_bus.saturated, rsp_bus.last_out};
               result_count++;
               if (got.sat) saturated_count++;
               if (got.acc_x !== want.acc_x) begin
                  $display("%0t acc_out_x expected %h actual %h", $time, want.acc_x, got.acc_x);
                  fail_count++;
               end
               if (got.acc_y !== want.acc_y) begin
                  $display("%0t acc_out_y expected %h actual %h", $time, want.acc_y, got.acc_y);
                  fail_count++;
               end
               if (got.acc_z !== want.acc_z) begin
                  $display("%0t acc_out_z expected %h actual %h", $time, want.acc_z, got.acc_z);
                  fail_count++;
               end
               if (got.sat !== want.sat) begin
                  $display("%0t saturated expected %b actual %b", $time, want.sat, got.sat);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t last_out expected %b actual %b", $time, want.last, got.last);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      row_type     rows[$];
      accel_type   none;
      logic [31:0] gm_list[4];
      logic [31:0] scale_list[4];
      none = '0;
      gm_list = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd3_276_800};
      scale_list = '{32'd148106, 32'hFFFF_FFFF, 32'd0, 32'd1};
      req_bus.valid = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.acc_in_x = '0;
      req_bus.acc_in_y = '0;
      req_bus.acc_in_z = '0;
      req_bus.last_in = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_GM_TOTAL;
      csr_bus.data = '0;
      gm_setting = GM_TOTAL_RESET;
      scale_setting = RADIUS_SCALE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The origin gets no pull, so the acceleration passes through unchanged.
      rows.push_back('{'{0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1}, 1'b1,
                       '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b0, 1'b1}});
      rows.push_back('{'{0, 0, 0, 0, 0, 0, 1'b0}, 1'b1, '{0, 0, 0, 1'b0, 1'b0}});
      rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b0}, 1'b0, none});
      rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1}, 1'b0, none});
      rows.push_back('{'{32'h0001_0000, 0, 0, 0, 0, 0, 1'b0}, 1'b0, none});
      rows.push_back('{'{0, 32'hFFFF_0000, 0, 0, 0, 0, 1'b0}, 1'b0, none});
      rows.push_back('{'{0, 0, 32'h0000_0001, 32'h8000_0000, 0, 0, 1'b0}, 1'b0, none});
      rows.push_back('{'{32'hFFFF_FFFF, 32'h0000_0001, 0, 32'h7FFF_FFFF, 0, 0, 1'b1}, 1'b0, none});
      rows.push_back('{'{32'h0100_0000, 32'hFF00_0000, 32'h0010_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0}, 1'b0, none});
      rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                         32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 1'b1}, 1'b0, none});

      for (int s = 0; s < 4; s++) begin
         write_reg(CSR_GM_TOTAL, gm_list[s]);
         write_reg(CSR_RADIUS_SCALE, scale_list[(s + 3) % 4]);
         foreach (rows[i]) send_particle(rows[i].p, rows[i].known && s == 0, rows[i].r);
         drain();
      end

      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0) begin
            write_reg(CSR_GM_TOTAL, GM_TOTAL_RESET);
            write_reg(CSR_RADIUS_SCALE, RADIUS_SCALE_RESET);
         end else begin
            write_reg(CSR_GM_TOTAL, (phase == 4) ? 32'hFFFF_FFFF : $urandom());
            write_reg(CSR_RADIUS_SCALE, (phase == 4) ? 32'h0000_0001
                                                     : $urandom_range(1, 32'h0008_0000));
         end
         idle_pct = (phase == 2) ? 0 : 13;
         for (int n = 0; n < 100; n++) begin
            send_particle(rand_particle(), 1'b0, none);
            if (phase == 1 && n == 50) begin
               req_bus.valid <= 1'b0;
               while (pending_accel.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      idle_pct = 13;

      $display("Checked %0d results (%0d saturated) over nine register settings,",
               result_count, saturated_count);
      $display("including the origin, zero scale and saturating extremes.");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_if.sv
hw/rtl/plummer_potential_accel.sv
verif/plummer_potential_accel_tb.sv
